// ===== rtl/core/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and constants shared by the checksummed frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam logic [7:0] READY_BYTE  = 8'h01;
  localparam logic [7:0] START_FINAL = 8'hFF;
  localparam logic [7:0] SUM_SEED    = 8'hFF;

  typedef enum logic [2:0] {
    K_PAYLOAD   = 3'd0,
    K_GOOD      = 3'd1,
    K_LCS_BAD   = 3'd2,
    K_DCS_BAD   = 3'd3,
    K_EMPTY     = 3'd4,
    K_NOT_READY = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_of_transfer;
  } item_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       last_payload;
    logic [7:0] payload_length;
  } res_t;

endpackage

// ===== rtl/core/cfd_in_reg.sv =====
// ----------------------------------------------------------------------------
// cfd_in_reg
// Input register: holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
module cfd_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  cfd_pkg::item_t in_item,
  input  logic          take,
  output logic          item_valid,
  output cfd_pkg::item_t item
);

  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/core/cfd_fsm.sv =====
// ----------------------------------------------------------------------------
// cfd_fsm
// Frame state machine: ready byte check, start code hunt, length and data
// checksums, payload marking.
// ----------------------------------------------------------------------------
module cfd_fsm (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  cfd_pkg::item_t item,
  output cfd_pkg::res_t  res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HUNT0, PH_HUNT1, PH_HUNTFF, PH_LEN, PH_LCS, PH_DATA, PH_DCS
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] b;
  logic [7:0] lcs_sum;

  assign b       = item.rx_byte;
  assign lcs_sum = frame_length + b;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    running_sum_next  = running_sum;
    res               = '0;
    res.kind          = cfd_pkg::K_PAYLOAD;
    res.payload_length = frame_length;
    if (item.first_of_transfer) begin
      bytes_seen_next  = '0;
      running_sum_next = '0;
      if (b == cfd_pkg::READY_BYTE) begin
        phase_next = PH_HUNT0;
      end else begin
        phase_next         = PH_IDLE;
        res.valid          = 1'b1;
        res.kind           = cfd_pkg::K_NOT_READY;
        res.payload_length = '0;
      end
    end else begin
      unique case (phase)
        PH_HUNT0: phase_next = (b == 8'h00) ? PH_HUNT1 : PH_HUNT0;
        PH_HUNT1: phase_next = (b == 8'h00) ? PH_HUNTFF : PH_HUNT0;
        PH_HUNTFF: begin
          if (b == cfd_pkg::START_FINAL) phase_next = PH_LEN;
          else if (b == 8'h00)           phase_next = PH_HUNTFF;
          else                           phase_next = PH_HUNT0;
        end
        PH_LEN: begin
          frame_length_next = b;
          phase_next        = PH_LCS;
        end
        PH_LCS: begin
          if (lcs_sum != 8'h00) begin
            phase_next = PH_HUNT0;
            res.valid  = 1'b1;
            res.kind   = cfd_pkg::K_LCS_BAD;
          end else begin
            bytes_seen_next  = '0;
            running_sum_next = cfd_pkg::SUM_SEED;
            phase_next       = (frame_length == 8'h00) ? PH_DCS : PH_DATA;
          end
        end
        PH_DATA: begin
          running_sum_next = running_sum + b;
          bytes_seen_next  = bytes_seen + 8'd1;
          res.valid        = 1'b1;
          res.kind         = cfd_pkg::K_PAYLOAD;
          res.payload_byte = b;
          if (bytes_seen_next == frame_length) begin
            res.last_payload = 1'b1;
            phase_next       = PH_DCS;
          end
        end
        PH_DCS: begin
          phase_next = PH_HUNT0;
          res.valid  = 1'b1;
          if (b != ~running_sum)            res.kind = cfd_pkg::K_DCS_BAD;
          else if (frame_length == 8'h00)   res.kind = cfd_pkg::K_EMPTY;
          else                              res.kind = cfd_pkg::K_GOOD;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      frame_length <= '0;
      bytes_seen   <= '0;
      running_sum  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

// ===== rtl/core/cfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// cfd_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module cfd_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  cfd_pkg::res_t res,
  output logic          free,
  output logic          m_tvalid,
  input  logic          m_tready,
  output cfd_pkg::res_t held
);

  assign free     = !m_tvalid || m_tready;
  assign m_tvalid = held.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (load) begin
      held.valid <= res.valid;
    end else if (m_tready) begin
      held.valid <= 1'b0;
    end
    if (load && res.valid) begin
      held.kind           <= res.kind;
      held.payload_byte   <= res.payload_byte;
      held.last_payload   <= res.last_payload;
      held.payload_length <= res.payload_length;
    end
  end

endmodule

// ===== rtl/core/checksummed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// checksummed_frame_deframer
// Byte-serial deframer: ready byte, 00 00 FF start code, length, checksums.
// ----------------------------------------------------------------------------
// One received byte per transfer, one byte per clock sustained. Each byte
// passes through an input register and one pass of the frame state machine
// into a result register, loaded as the byte leaves the input register;
// bytes that give no result (hunting, length, idle) are absorbed
// without output. Payload bytes stream out with tlast on the final one, and
// each frame ends in a status transfer whose tuser kind reports good, empty,
// bad length checksum or bad data checksum; a transfer start that is not the
// ready byte gives a not-ready status and bytes are then dropped until the
// next transfer start. Back-pressure on the output stalls the input side.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic        s_tuser,   // first_of_transfer
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // payload_byte [7:0], payload_length [15:8]
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast    // last_payload
);

  cfd_pkg::item_t in_item, item;
  cfd_pkg::res_t  res, held;
  logic           item_valid;
  logic           free;
  logic           take;

  assign in_item.rx_byte           = s_tdata;
  assign in_item.first_of_transfer = s_tuser;
  assign take                      = item_valid && free;

  cfd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  cfd_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .item (item),
    .res  (res)
  );

  cfd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res      (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .held     (held)
  );

  assign m_tdata = {held.payload_length, held.payload_byte};
  assign m_tuser = held.kind;
  assign m_tlast = held.last_payload;

endmodule

// ===== bench/checksummed_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_deframer_tb
// Self-checking bench for the byte-serial frame deframer.
// ----------------------------------------------------------------------------
// Byte streams go in through the input stream port: ready bytes, start codes,
// good and corrupted frames, not-ready transfer starts, truncated frames and
// noise. A cycle-free model of the frame state machine runs on every accepted
// byte and queues the status or payload transfer due. Outputs are compared
// field by field, in order. Both sides stall at random except in the last run.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer_tb;

  typedef enum logic [2:0] {
    LS_IDLE, LS_HUNT0, LS_HUNT1, LS_HUNTFF, LS_LEN, LS_LCS, LS_DATA, LS_DCS
  } link_state_t;

  typedef struct {
    cfd_pkg::kind_t kind;
    logic [7:0]     data;
    logic           last;
    logic [7:0]     len;
  } deframe_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  cfd_pkg::item_t  pending_bytes[$];
  deframe_result_t expected_results[$];
  cfd_pkg::item_t  next_byte;

  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 71;
  int unsigned fail_count = 0;
  int unsigned bytes_queued = 0;
  bit          transfer_open = 1'b0;

  // model state
  link_state_t link_st = LS_IDLE;
  logic [7:0]  frame_len = 8'h00;
  logic [7:0]  payload_seen = 8'h00;
  logic [7:0]  payload_sum = 8'h00;

  checksummed_frame_deframer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void deframe_byte(logic [7:0] b, logic first);
    deframe_result_t r;
    bit              emit;
    logic [7:0]      lcs_sum;
    emit = 1'b0;
    r.kind = cfd_pkg::K_PAYLOAD;
    r.data = 8'h00;
    r.last = 1'b0;
    r.len = frame_len;
    if (first) begin
      payload_seen = 8'h00;
      payload_sum = 8'h00;
      if (b == cfd_pkg::READY_BYTE) begin
        link_st = LS_HUNT0;
      end else begin
        link_st = LS_IDLE;
        r.kind = cfd_pkg::K_NOT_READY;
        r.len = 8'h00;
        emit = 1'b1;
      end
    end else begin
      case (link_st)
        LS_HUNT0: link_st = (b == 8'h00) ? LS_HUNT1 : LS_HUNT0;
        LS_HUNT1: link_st = (b == 8'h00) ? LS_HUNTFF : LS_HUNT0;
        LS_HUNTFF: begin
          if (b == cfd_pkg::START_FINAL) link_st = LS_LEN;
          else if (b == 8'h00) link_st = LS_HUNTFF;
          else link_st = LS_HUNT0;
        end
        LS_LEN: begin
          frame_len = b;
          link_st = LS_LCS;
        end
        LS_LCS: begin
          lcs_sum = frame_len + b;
          if (lcs_sum != 8'h00) begin
            link_st = LS_HUNT0;
            r.kind = cfd_pkg::K_LCS_BAD;
            r.len = frame_len;
            emit = 1'b1;
          end else begin
            payload_seen = 8'h00;
            payload_sum = cfd_pkg::SUM_SEED;
            link_st = (frame_len == 8'h00) ? LS_DCS : LS_DATA;
          end
        end
        LS_DATA: begin
          payload_sum = payload_sum + b;
          payload_seen = payload_seen + 8'h01;
          r.data = b;
          r.last = (payload_seen == frame_len);
          if (r.last) link_st = LS_DCS;
          emit = 1'b1;
        end
        LS_DCS: begin
          if (b != ~payload_sum) r.kind = cfd_pkg::K_DCS_BAD;
          else if (frame_len == 8'h00) r.kind = cfd_pkg::K_EMPTY;
          else r.kind = cfd_pkg::K_GOOD;
          link_st = LS_HUNT0;
          emit = 1'b1;
        end
        default: link_st = LS_IDLE;
      endcase
    end
    if (emit) expected_results.push_back(r);
  endfunction

  function automatic void check_result();
    deframe_result_t e;
    if (expected_results.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected transfer: kind %0d data %02h last %0b len %02h",
                 m_tuser, m_tdata[7:0], m_tlast, m_tdata[15:8]);
      fail_count++;
    end else begin
      e = expected_results.pop_front();
      if (m_tuser !== e.kind || m_tdata[7:0] !== e.data || m_tlast !== e.last ||
          m_tdata[15:8] !== e.len) begin
        if (fail_count < 10)
          $display("mismatch: exp %0d/%02h/%0b/%02h got %0d/%02h/%0b/%02h",
                   e.kind, e.data, e.last, e.len,
                   m_tuser, m_tdata[7:0], m_tlast, m_tdata[15:8]);
        fail_count++;
      end
    end
  endfunction

  // input side: accepted bytes go through the model, then the next is offered
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) deframe_byte(s_tdata, s_tuser);
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          s_tdata <= next_byte.rx_byte;
          s_tuser <= next_byte.first_of_transfer;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic first);
    cfd_pkg::item_t it;
    it.rx_byte = b;
    it.first_of_transfer = first;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  task automatic open_transfer();
    queue_byte(cfd_pkg::READY_BYTE, 1'b1);
    transfer_open = 1'b1;
  endtask

  // cut_at < 0 or >= len: whole frame; else a new transfer starts there
  task automatic queue_frame(input int len, input bit bad_lcs, input bit bad_dcs,
                             input int cut_at);
    logic [7:0] sum;
    logic [7:0] lcs;
    logic [7:0] dcs;
    logic [7:0] p;
    if (!transfer_open) open_transfer();
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(cfd_pkg::START_FINAL, 1'b0);
    queue_byte(len[7:0], 1'b0);
    lcs = -len[7:0];
    if (bad_lcs) lcs = lcs + 8'($urandom_range(1, 255));
    queue_byte(lcs, 1'b0);
    if (bad_lcs) return;
    sum = cfd_pkg::SUM_SEED;
    for (int i = 0; i < len; i++) begin
      if (i == cut_at) begin
        open_transfer();
        return;
      end
      p = 8'($urandom);
      queue_byte(p, 1'b0);
      sum = sum + p;
    end
    dcs = ~sum;
    if (bad_dcs) dcs = dcs ^ 8'($urandom_range(1, 255));
    queue_byte(dcs, 1'b0);
  endtask

  task automatic queue_random_traffic(input int unsigned upto);
    int unsigned pick;
    int          len;
    logic [7:0]  b;
    while (bytes_queued < upto) begin
      pick = $urandom_range(99);
      len = $urandom_range(0, 8);
      if (pick < 55) begin
        queue_frame(len, 1'b0, 1'b0, -1);
      end else if (pick < 63) begin
        queue_frame(len, 1'b1, 1'b0, -1);
      end else if (pick < 71) begin
        queue_frame(len, 1'b0, 1'b1, -1);
      end else if (pick < 76) begin
        len = $urandom_range(1, 8);
        queue_frame(len, 1'b0, 1'b0, $urandom_range(0, len - 1));
      end else if (pick < 82) begin
        do b = 8'($urandom); while (b == cfd_pkg::READY_BYTE);
        queue_byte(b, 1'b1);
        transfer_open = 1'b0;
        repeat ($urandom_range(0, 3)) queue_byte(8'($urandom), 1'b0);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(2))
            0: queue_byte(8'h00, 1'b0);
            1: queue_byte(cfd_pkg::START_FINAL, 1'b0);
            default: queue_byte(8'($urandom), 1'b0);
          endcase
        end
      end else if (pick < 95) begin
        open_transfer();
      end else begin
        if (!transfer_open) open_transfer();
        repeat ($urandom_range(1, 3)) queue_byte(8'h00, 1'b0);
        queue_frame(len, 1'b0, 1'b0, -1);
      end
    end
  endtask

  task automatic wait_input_drained();
    while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: idle byte, not-ready start, zero run, good frame, empty frame,
    // bad length checksum at the largest length, bad data checksum
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    open_transfer();
    queue_byte(8'h00, 1'b0);
    queue_frame(2, 1'b0, 1'b0, -1);
    queue_frame(0, 1'b0, 1'b0, -1);
    queue_frame(255, 1'b1, 1'b0, -1);
    queue_frame(1, 1'b0, 1'b1, -1);

    queue_random_traffic(150);
    wait_input_drained();

    send_idle_pct = 71;
    recv_idle_pct = 38;
    queue_random_traffic(300);
    wait_input_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_frame(255, 1'b0, 1'b0, -1);
    queue_random_traffic(600);
    wait_input_drained();

    for (int n = 0; n < 500 && expected_results.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      if (fail_count < 10)
        $display("%0d expected transfers never arrived", expected_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("checksummed_frame_deframer regression: pass");
    end else begin
      $display("checksummed_frame_deframer regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("checksummed_frame_deframer regression: fail");
    $finish;
  end

endmodule

// ===== checksummed_frame_deframer.f =====
rtl/core/cfd_pkg.sv
rtl/core/cfd_in_reg.sv
rtl/core/cfd_fsm.sv
rtl/core/cfd_out_reg.sv
rtl/core/checksummed_frame_deframer.sv
bench/checksummed_frame_deframer_tb.sv
